### rtl/blocked_task_priority_table_core_defines.svh
// Assertion macros for the blocked task priority table.
// Used by the top level; expects clk and rst_n in scope.
`ifndef BLOCKED_TASK_PRIORITY_TABLE_CORE_DEFINES_SVH
`define BLOCKED_TASK_PRIORITY_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BTPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define BTPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/btpt_pkg.sv
// Shared codes and the result record of the blocked task priority table.
// No dependencies.
`default_nettype none

package btpt_pkg;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_PROBE  = 2'd2;
  localparam logic [1:0] CMD_SPARE  = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_DUP       = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // One result record, port widths
  typedef struct packed {
    logic       was_present;
    logic [1:0] status;
    logic       best_valid;
    logic [7:0] best_id;
    logic [4:0] occupancy;
  } btpt_res_t;

endpackage

`default_nettype wire

### rtl/btpt_front.sv
// Front end: accepts commands, normalizes them and holds them in a 2-entry queue.
// Depends on btpt_pkg.
`default_nettype none

module btpt_front #(
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  output logic                     busy,
  input  wire  [1:0]               in_command,
  input  wire  [7:0]               in_task_id,
  input  wire  [7:0]               in_task_priority,
  input  wire                      pop,
  output logic                     q_valid,
  output logic [1:0]               q_cmd,
  output logic [ID_BITS-1:0]       q_id,
  output logic [PRIORITY_BITS-1:0] q_prio
);
  import btpt_pkg::*;

  logic [ID_BITS+7:0]       id_ext;
  logic [PRIORITY_BITS+7:0] prio_ext;
  logic [1:0]               cmd_cls;
  logic                     push;

  logic [1:0]               cmd_q_r  [2];
  logic [ID_BITS-1:0]       id_q_r   [2];
  logic [PRIORITY_BITS-1:0] prio_q_r [2];
  logic                     wr_ptr_r;
  logic                     rd_ptr_r;
  logic [1:0]               fill_r;

  // Field widths: keep the low bits the table works with
  assign id_ext   = {{ID_BITS{1'b0}}, in_task_id};
  assign prio_ext = {{PRIORITY_BITS{1'b0}}, in_task_priority};

  // Command classification: the spare code acts as a probe
  always_comb begin
    unique case (in_command) inside
      CMD_INSERT:            cmd_cls = CMD_INSERT;
      CMD_REMOVE:            cmd_cls = CMD_REMOVE;
      CMD_PROBE, CMD_SPARE:  cmd_cls = CMD_PROBE;
      default:               cmd_cls = CMD_PROBE;
    endcase
  end

  assign busy    = (fill_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (fill_r != 2'd0);
  assign q_cmd   = cmd_q_r[rd_ptr_r];
  assign q_id    = id_q_r[rd_ptr_r];
  assign q_prio  = prio_q_r[rd_ptr_r];

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      cmd_q_r[wr_ptr_r]  <= cmd_cls;
      id_q_r[wr_ptr_r]   <= id_ext[ID_BITS-1:0];
      prio_q_r[wr_ptr_r] <= prio_ext[PRIORITY_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/btpt_back.sv
// Back end: scans the table memory one slot a cycle, then applies the command
// and issues the result. Depends on btpt_pkg.
`default_nettype none

module btpt_back #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 8
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      q_valid,
  input  wire  [1:0]               q_cmd,
  input  wire  [ID_BITS-1:0]       q_id,
  input  wire  [PRIORITY_BITS-1:0] q_prio,
  output logic                     pop,
  output logic                     res_valid,
  output btpt_pkg::btpt_res_t      res
);
  import btpt_pkg::*;

  localparam int SLOT_BITS = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_BITS  = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]               state_r, state_nxt;

  // Command being executed
  logic [1:0]               cmd_r;
  logic [ID_BITS-1:0]       id_r;
  logic [PRIORITY_BITS-1:0] prio_r;

  // Table storage
  logic [ID_BITS-1:0]       mem_id   [TABLE_DEPTH];
  logic [PRIORITY_BITS-1:0] mem_prio [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]   valid_r;

  // Read stage
  logic [SLOT_BITS-1:0]     rd_addr_r;
  logic                     q_live_r;
  logic                     q_vld_r;
  logic [ID_BITS-1:0]       q_id_r;
  logic [PRIORITY_BITS-1:0] q_prio_r;
  logic [SLOT_BITS-1:0]     q_slot_r;

  // Scan accumulators
  logic                     hit_r;
  logic [SLOT_BITS-1:0]     hit_slot_r;
  logic                     free_found_r;
  logic [SLOT_BITS-1:0]     free_slot_r;
  logic [CNT_BITS-1:0]      cnt_r;
  logic                     bv_r;
  logic [PRIORITY_BITS-1:0] bp_r;
  logic [ID_BITS-1:0]       bid_r;

  logic                     res_valid_r;
  btpt_res_t                res_r;

  logic                     last_addr;
  logic                     match;
  logic                     take_free;
  logic                     counted;
  logic                     better;
  logic                     ins_ok;
  logic                     rem_ok;
  logic                     new_better;
  logic                     fin_bv;
  logic [ID_BITS-1:0]       fin_bid;
  logic [CNT_BITS-1:0]      fin_cnt;
  logic [1:0]               fin_status;
  logic [ID_BITS+7:0]       bid_ext;
  logic [CNT_BITS+4:0]      cnt_ext;

  assign pop       = (state_r == S_IDLE) && q_valid;
  assign last_addr = (rd_addr_r == SLOT_BITS'(TABLE_DEPTH - 1));

  // Per-slot evaluation of the registered read data
  assign match     = q_live_r && q_vld_r && (q_id_r == id_r);
  assign take_free = q_live_r && !q_vld_r && !free_found_r;
  assign counted   = q_live_r && q_vld_r && !(match && (cmd_r == CMD_REMOVE));
  assign better    = counted && (q_prio_r != '0) &&
                     (!bv_r || (q_prio_r > bp_r) || ((q_prio_r == bp_r) && (q_id_r < bid_r)));

  // Finish: fold in a new entry and pick the status
  assign ins_ok     = (cmd_r == CMD_INSERT) && !hit_r && free_found_r;
  assign rem_ok     = (cmd_r == CMD_REMOVE) && hit_r;
  assign new_better = ins_ok && (prio_r != '0) &&
                      (!bv_r || (prio_r > bp_r) || ((prio_r == bp_r) && (id_r < bid_r)));
  assign fin_bv     = bv_r || new_better;
  assign fin_bid    = new_better ? id_r : bid_r;
  assign fin_cnt    = cnt_r + (ins_ok ? CNT_BITS'(1) : CNT_BITS'(0));
  assign bid_ext    = {8'd0, fin_bid};
  assign cnt_ext    = {5'd0, fin_cnt};

  always_comb begin
    case (cmd_r)
      CMD_INSERT: fin_status = hit_r ? ST_DUP : (free_found_r ? ST_DONE : ST_FULL);
      CMD_REMOVE: fin_status = hit_r ? ST_DONE : ST_NOT_FOUND;
      default:    fin_status = ST_DONE;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (q_valid) state_nxt = S_SCAN;
      S_SCAN:  if (last_addr) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      q_live_r    <= 1'b0;
      valid_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      q_live_r    <= (state_r == S_SCAN);
      res_valid_r <= (state_r == S_FIN);
      if (state_r == S_FIN) begin
        if (ins_ok) valid_r[free_slot_r] <= 1'b1;
        if (rem_ok) valid_r[hit_slot_r]  <= 1'b0;
      end
    end
  end

  // Command latch, address counter and accumulators
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r        <= q_cmd;
      id_r         <= q_id;
      prio_r       <= q_prio;
      rd_addr_r    <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      cnt_r        <= '0;
      bv_r         <= 1'b0;
      bp_r         <= '0;
      bid_r        <= '0;
    end else begin
      if ((state_r == S_SCAN) && !last_addr) rd_addr_r <= rd_addr_r + SLOT_BITS'(1);
      if (match) begin
        hit_r      <= 1'b1;
        hit_slot_r <= q_slot_r;
      end
      if (take_free) begin
        free_found_r <= 1'b1;
        free_slot_r  <= q_slot_r;
      end
      if (counted) cnt_r <= cnt_r + CNT_BITS'(1);
      if (better) begin
        bv_r  <= 1'b1;
        bp_r  <= q_prio_r;
        bid_r <= q_id_r;
      end
    end
  end

  // Table memory: one write, one registered read
  always_ff @(posedge clk) begin
    if ((state_r == S_FIN) && ins_ok) begin
      mem_id[free_slot_r]   <= id_r;
      mem_prio[free_slot_r] <= prio_r;
    end
    q_id_r   <= mem_id[rd_addr_r];
    q_prio_r <= mem_prio[rd_addr_r];
    q_vld_r  <= valid_r[rd_addr_r];
    q_slot_r <= rd_addr_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      res_r.was_present <= hit_r;
      res_r.status      <= fin_status;
      res_r.best_valid  <= fin_bv;
      res_r.best_id     <= bid_ext[7:0];
      res_r.occupancy   <= cnt_ext[4:0];
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

`default_nettype wire

### rtl/blocked_task_priority_table_core.sv
// Top level of the blocked task priority table: front queue plus scan engine.
// Depends on btpt_pkg, btpt_front, btpt_back and the assertion macro header.
//
//   channel   handshake            payload
//   input     start, busy          in_command, in_task_id, in_task_priority
//   result    out_valid (1 cycle)  out_was_present, out_status, out_best_valid,
//                                  out_best_id, out_occupancy
//
// The engine works on one item at a time: it takes the item from the queue,
// streams the slots through the single table read port, drains the read stage,
// then updates the table and registers the result before it takes the next one.
// The 2-entry front queue keeps taking items while the engine works; busy rises
// only when both entries are held. Reset empties the table and the queue at once.
// out_valid pulses for one cycle per item and cannot be held off.
`default_nettype none
`include "blocked_task_priority_table_core_defines.svh"

module blocked_task_priority_table_core #(
  parameter int TABLE_DEPTH   = 16,
  parameter int ID_BITS       = 8,
  parameter int PRIORITY_BITS = 8
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire  [1:0] in_command,
  input  wire  [7:0] in_task_id,
  input  wire  [7:0] in_task_priority,
  output logic       out_valid,
  output logic       out_was_present,
  output logic [1:0] out_status,
  output logic       out_best_valid,
  output logic [7:0] out_best_id,
  output logic [4:0] out_occupancy
);
  import btpt_pkg::*;

  logic                     pop;
  logic                     q_valid;
  logic [1:0]               q_cmd;
  logic [ID_BITS-1:0]       q_id;
  logic [PRIORITY_BITS-1:0] q_prio;
  logic                     res_valid;
  btpt_res_t                res;

  btpt_front #(
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_task_id       (in_task_id),
    .in_task_priority (in_task_priority),
    .pop              (pop),
    .q_valid          (q_valid),
    .q_cmd            (q_cmd),
    .q_id             (q_id),
    .q_prio           (q_prio)
  );

  btpt_back #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_id      (q_id),
    .q_prio    (q_prio),
    .pop       (pop),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_valid       = res_valid;
  assign out_was_present = res.was_present;
  assign out_status      = res.status;
  assign out_best_valid  = res.best_valid;
  assign out_best_id     = res.best_id;
  assign out_occupancy   = res.occupancy;

  // Results are spaced by a full table scan
  `BTPT_ASSERT_NXT(a_res_spacing, out_valid, !out_valid, "back-to-back result strobes")
  // A duplicate insert implies the id was held; a miss implies it was not
  `BTPT_ASSERT_IMP(a_dup_present, out_valid && (out_status == ST_DUP), out_was_present, "dup without hit")
  `BTPT_ASSERT_IMP(a_miss_absent, out_valid && (out_status == ST_NOT_FOUND), !out_was_present, "miss with hit")
  // No winner reads as id zero
  `BTPT_ASSERT_IMP(a_best_zero, out_valid && !out_best_valid, out_best_id == 8'd0, "stale best id")

endmodule

`default_nettype wire
